[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/rsc_pkg.sv]
`timescale 1ns / 1ps

package rsc_pkg;

    // field and register widths
    localparam int BASE_W    = 6;
    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_BASE = 2'd1;

    // base register reset values and clamp limits
    localparam logic [BASE_W-1:0] SRC_BASE_RST = 6'd10;
    localparam logic [BASE_W-1:0] TGT_BASE_RST = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;

    // character codes
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] DIGIT_TEN  = 8'd10;

    // input beat
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              empty_res;
        logic              last_digit;
    } t_out_item;

    // command from the sequencer to the emitter
    typedef struct packed {
        logic               start;
        logic               empty;
        logic [COUNT_W-1:0] count;
    } t_emit_cmd;

    // digit store write
    typedef struct packed {
        logic              en;
        logic [5:0]        addr;
        logic [BASE_W-1:0] digit;
    } t_store_wr;

    // top level sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

[rtl/rsc_mac.sv]
`timescale 1ns / 1ps

module rsc_mac #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_clear,
    input  logic [rsc_pkg::BASE_W-1:0]    i_base,
    input  logic [rsc_pkg::BASE_W-1:0]    i_digit,
    output logic                          o_done,
    output logic [VALUE_WIDTH-1:0]        o_acc
);
    import rsc_pkg::*;

    localparam int STEP_W = $clog2(BASE_W);

    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic [VALUE_WIDTH-1:0] r_sum, n_sum;
    logic [BASE_W-1:0]      r_bits, n_bits;
    logic [BASE_W-1:0]      r_digit, n_digit;
    logic [STEP_W-1:0]      r_step, n_step;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic                   last_step;

    // one base bit per cycle, msb first: sum = 2*sum + bit*acc, digit on the last step
    always_comb begin
        last_step = (r_step == STEP_W'(BASE_W - 1));
        n_acc     = r_acc;
        n_sum     = r_sum;
        n_bits    = r_bits;
        n_digit   = r_digit;
        n_step    = r_step;
        n_busy    = r_busy;
        n_done    = 1'b0;
        if (i_clear) begin
            n_acc = '0;
        end
        if (i_start) begin
            n_sum   = '0;
            n_bits  = i_base;
            n_digit = i_digit;
            n_step  = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_sum  = {r_sum[VALUE_WIDTH-2:0], 1'b0}
                   + (r_bits[BASE_W-1] ? r_acc : '0)
                   + (last_step ? VALUE_WIDTH'(r_digit) : '0);
            n_bits = {r_bits[BASE_W-2:0], 1'b0};
            n_step = r_step + 1'b1;
            if (last_step) begin
                n_acc  = n_sum;
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_acc  <= n_acc;
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_bits  <= n_bits;
        r_digit <= n_digit;
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

[rtl/rsc_div.sv]
`timescale 1ns / 1ps

module rsc_div #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_load,
    input  logic [VALUE_WIDTH-1:0]        i_value,
    input  logic [rsc_pkg::BASE_W-1:0]    i_base,
    output logic                          o_done,
    output logic                          o_zero,
    output logic [rsc_pkg::BASE_W-1:0]    o_digit
);
    import rsc_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [BASE_W-1:0]      r_rem, n_rem;
    logic [BASE_W-1:0]      r_base, n_base;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [BASE_W:0]        rem_sh;
    logic                   ge;

    // restoring division, one dividend bit per cycle; remainder stays below the base
    always_comb begin
        rem_sh = {r_rem, r_quo[VALUE_WIDTH-1]};
        ge     = (rem_sh >= {1'b0, r_base});
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_base = r_base;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            if (i_load) begin
                n_quo = i_value;
            end
            n_rem  = '0;
            n_base = i_base;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? BASE_W'(rem_sh - {1'b0, r_base}) : BASE_W'(rem_sh);
            n_quo = {r_quo[VALUE_WIDTH-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // quotient and remainder shift registers
    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_base <= n_base;
    end

    assign o_done  = r_done;
    assign o_zero  = (r_quo == '0);
    assign o_digit = r_rem;

endmodule

[rtl/rsc_emit.sv]
`timescale 1ns / 1ps

module rsc_emit #(
    parameter int MAX_DIGITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rsc_pkg::t_store_wr     i_wr,
    input  rsc_pkg::t_emit_cmd     i_cmd,
    output logic                   o_strobe,
    output rsc_pkg::t_out_item     o_res,
    output logic                   o_done
);
    import rsc_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIGITS);

    logic [BASE_W-1:0] r_mem [MAX_DIGITS];
    logic [BASE_W-1:0] r_q;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_active, n_active;
    logic              r_rd_vld, n_rd_vld;
    logic              r_rd_last, n_rd_last;
    logic              r_empty_vld, n_empty_vld;

    // digit value to upper-case character
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = CHAR_W'(d);
        return (dw < DIGIT_TEN) ? dw + CH_ZERO : dw - DIGIT_TEN + CH_UPPER_A;
    endfunction

    // digit store, written by the divider, read most significant first
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[ADDR_W-1:0]] <= i_wr.digit;
        end
        r_q <= r_mem[r_addr];
    end

    // read sequencer walking the store downward
    always_comb begin
        n_addr      = r_addr;
        n_active    = r_active;
        n_rd_vld    = 1'b0;
        n_rd_last   = 1'b0;
        n_empty_vld = 1'b0;
        if (i_cmd.start) begin
            if (i_cmd.empty) begin
                n_empty_vld = 1'b1;
            end else begin
                n_addr   = ADDR_W'(i_cmd.count - 1'b1);
                n_active = 1'b1;
            end
        end else if (r_active) begin
            n_rd_vld  = 1'b1;
            n_rd_last = (r_addr == '0);
            if (r_addr == '0) begin
                n_active = 1'b0;
            end else begin
                n_addr = r_addr - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_empty_vld <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_active    <= n_active;
            r_rd_vld    <= n_rd_vld;
            r_rd_last   <= n_rd_last;
            r_empty_vld <= n_empty_vld;
            r_addr      <= n_addr;
        end
    end

    // result beat
    assign o_strobe         = r_rd_vld | r_empty_vld;
    assign o_res.digit_char = r_empty_vld ? '0 : to_ascii(r_q);
    assign o_res.empty_res  = r_empty_vld;
    assign o_res.last_digit = r_empty_vld | r_rd_last;
    assign o_done           = o_strobe & o_res.last_digit;

endmodule

[rtl/radix_string_converter_unit.sv]
`timescale 1ns / 1ps
// channel   ports                                        handshake
// -------   -------------------------------------------  -------------------------------
// input     i_start, o_busy, i_in                        beat taken when i_start & !o_busy
// result    o_strobe, o_res                              beat valid for one cycle, no stall
// config    i_cfg_valid, o_cfg_ready, i_cfg_index/data   write when valid & ready
//
// a character is taken; the accumulator is multiplied bit-serially by the source base
// (one base bit per cycle through a VALUE_WIDTH shift-and-add), the digit is added, then
// finished. a last character then runs the restoring divider once per output digit, then
// reads the digit store and sends the beats; a zero value sends one empty beat instead.
// synchronous active-low reset clears the accumulator and all control; digit store
// is not cleared. results cannot be stalled; o_busy stays high until the last beat.
`include "assert_macros.svh"

module radix_string_converter_unit #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  rsc_pkg::t_in_item                i_in,
    output logic                             o_strobe,
    output rsc_pkg::t_out_item               o_res,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rsc_pkg::BASE_W-1:0]       i_cfg_data
);
    import rsc_pkg::*;

    t_state             r_state, n_state;
    logic [BASE_W-1:0]  r_src_base, r_tgt_base;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_last, n_last;
    logic               accept;
    logic               mac_start, mac_clear, mac_done;
    logic [VALUE_WIDTH-1:0] mac_acc;
    logic               div_start, div_load, div_done, div_zero;
    logic [BASE_W-1:0]  div_digit;
    logic [BASE_W-1:0]  in_digit;
    logic [COUNT_W-1:0] cnt_inc;
    t_emit_cmd          emit_cmd;
    t_store_wr          store_wr;
    logic               emit_done;

    // base register limited to the supported range
    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        if (b < BASE_MIN) begin
            return BASE_MIN;
        end else if (b > BASE_MAX) begin
            return BASE_MAX;
        end
        return b;
    endfunction

    // character to digit value, anything else counts as zero
    function automatic logic [BASE_W-1:0] char_value(input logic [CHAR_W-1:0] c);
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            return BASE_W'(c - CH_ZERO);
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            return BASE_W'(c - CH_LOWER_A + DIGIT_TEN);
        end else if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            return BASE_W'(c - CH_UPPER_A + DIGIT_TEN);
        end
        return '0;
    endfunction

    assign o_busy      = (r_state != S_IDLE);
    assign accept      = i_start & ~o_busy;
    assign o_cfg_ready = 1'b1;
    assign in_digit    = char_value(i_in.char_code);
    assign cnt_inc     = r_cnt + 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base <= SRC_BASE_RST;
            r_tgt_base <= TGT_BASE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SRC_BASE: r_src_base <= i_cfg_data;
                CFG_TGT_BASE: r_tgt_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: multiply-accumulate; on a last character divide unless zero, then emit
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_last    = r_last;
        mac_start = 1'b0;
        mac_clear = 1'b0;
        div_start = 1'b0;
        div_load  = 1'b0;
        emit_cmd  = '0;
        store_wr  = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    mac_start = 1'b1;
                    n_last    = i_in.is_last;
                    n_state   = S_MAC;
                end
            end
            S_MAC: begin
                if (mac_done) begin
                    if (!r_last) begin
                        n_state = S_IDLE;
                    end else if (mac_acc == '0) begin
                        mac_clear      = 1'b1;
                        emit_cmd.start = 1'b1;
                        emit_cmd.empty = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        mac_clear = 1'b1;
                        div_start = 1'b1;
                        div_load  = 1'b1;
                        n_cnt     = '0;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    store_wr.en    = 1'b1;
                    store_wr.addr  = r_cnt[5:0];
                    store_wr.digit = div_digit;
                    n_cnt          = cnt_inc;
                    if (div_zero || cnt_inc == COUNT_W'(MAX_DIGITS)) begin
                        emit_cmd.start = 1'b1;
                        emit_cmd.count = cnt_inc;
                        n_state        = S_EMIT;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

    rsc_mac #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_clear (mac_clear),
        .i_base  (clamp_base(r_src_base)),
        .i_digit (in_digit),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    rsc_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_load  (div_load),
        .i_value (mac_acc),
        .i_base  (clamp_base(r_tgt_base)),
        .o_done  (div_done),
        .o_zero  (div_zero),
        .o_digit (div_digit)
    );

    rsc_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (store_wr),
        .i_cmd    (emit_cmd),
        .o_strobe (o_strobe),
        .o_res    (o_res),
        .o_done   (emit_done)
    );

    // checks
    `ASSERT_CLK(a_strobe_busy, i_clk, i_rst_n, o_strobe |-> o_busy, "result beat while idle")
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, accept |=> o_busy, "no busy after input beat")
    `ASSERT_CLK(a_last_idle, i_clk, i_rst_n, (o_strobe && o_res.last_digit) |=> !o_busy,
        "still busy after final beat")
    `ASSERT_NEVER(a_empty_flag, i_clk, i_rst_n,
        o_strobe && o_res.empty_res && (!o_res.last_digit || o_res.digit_char != 8'd0),
        "empty beat malformed")

endmodule
